### hw/rtl/transition_easing_curve_defines.svh
// Assertion macros for the transition easing curve block.
// Used by the top level only; needs a clock named clock and a reset named reset.
`ifndef TRANSITION_EASING_CURVE_DEFINES_SVH
`define TRANSITION_EASING_CURVE_DEFINES_SVH

// same-cycle implication
`define TEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/tec_pkg.sv
// Shared constants and elaboration-time helpers for the transition easing curve.
// No dependencies.
package tec_pkg;

   localparam int LOG_BITS  = 24;
   localparam int MANT_BITS = 30;

   localparam int FRAC_BITS_DEFAULT     = 16;
   localparam int EXP_FRAC_BITS_DEFAULT = 12;
   localparam int STEP_BITS_DEFAULT     = 10;

   localparam logic [2:0] MODE_JUMP     = 3'd0;
   localparam logic [2:0] MODE_LINEAR   = 3'd1;
   localparam logic [2:0] MODE_STEP     = 3'd2;
   localparam logic [2:0] MODE_EASE_IN  = 3'd3;
   localparam logic [2:0] MODE_EASE_OUT = 3'd4;
   localparam logic [2:0] MODE_IN_OUT   = 3'd5;

   localparam logic [1:0] REG_MODE       = 2'd0;
   localparam logic [1:0] REG_STEP_COUNT = 2'd1;
   localparam logic [1:0] REG_EXPONENT   = 2'd2;

   localparam int STEP_COUNT_RESET = 4;

   function automatic longint unsigned tec_isqrt(input longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bits;
      rem  = v;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > rem) bits = bits >> 2;
      while (bits != 0) begin
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // 2^(2^-i) in Q2.30, by repeated integer square roots of 2.0
   function automatic longint unsigned tec_root(input int i);
      longint unsigned r;
      r = 64'd2 << MANT_BITS;
      for (int k = 1; k <= i; k++) r = tec_isqrt(r << MANT_BITS);
      return r;
   endfunction

endpackage

### hw/rtl/transition_easing_curve.sv
// Transition easing curve: maps a Q1.F progress amount to an eased amount.
// Depends on tec_pkg, tec_log, tec_exp and transition_easing_curve_defines.svh.
//
// One progress item is taken every clock, except while the pipeline holds; each result
// passes through the 24-stage log squaring chain and the 24-stage root multiply chain
// used by the ease curves. The step divider runs in FRAC_BITS+1 stages alongside. The
// whole pipeline holds while a result waits at the output register. Configuration
// writes take effect at once and belong in idle time.
`include "transition_easing_curve_defines.svh"

module transition_easing_curve
   import tec_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
   parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEFAULT,
   parameter int STEP_BITS     = STEP_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FRAC_BITS:0]        req_progress,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FRAC_BITS:0]        rsp_eased,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [((STEP_BITS > EXP_FRAC_BITS+4) ? STEP_BITS : EXP_FRAC_BITS+4)-1:0] csr_data
);

   localparam int F   = FRAC_BITS;
   localparam int SB  = STEP_BITS;
   localparam int EW  = EXP_FRAC_BITS + 4;
   localparam int CW  = $clog2(F + 1);
   localparam int LW  = CW + LOG_BITS;
   localparam int MW  = LW + 4;
   localparam int IPW = MW - LOG_BITS;
   localparam int NW  = F + SB + 1;
   localparam int SW  = $clog2(MANT_BITS + 2);
   localparam int YW  = MANT_BITS + 2;
   localparam int PL  = LOG_BITS + 2;
   localparam int PM  = PL + 1;
   localparam int PY  = PM + LOG_BITS;
   localparam int PR  = PY + 1;
   localparam int PD  = F + 2;
   localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
   localparam logic [F:0] HALF = ONE >> 1;

   logic [2:0]    mode_ff;
   logic [SB-1:0] step_count_ff;
   logic [EW-1:0] exponent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LINEAR;
         step_count_ff <= SB'(STEP_COUNT_RESET);
         exponent_ff   <= EW'(1) << (EXP_FRAC_BITS + 1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:       mode_ff       <= csr_data[2:0];
            REG_STEP_COUNT: step_count_ff <= csr_data[SB-1:0];
            REG_EXPONENT:   exponent_ff   <= csr_data[EW-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [F:0] rsp_eased_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_eased = rsp_eased_ff;

   // ---- entry stage
   logic [F:0]      a_sat, x_in;
   logic            po_in, pf_in;
   logic [F+SB:0]   step_prod;
   logic [SB:0]     step_q;
   logic [SB-1:0]   d;
   logic [NW-1:0]   num_in;

   always_comb begin
      a_sat = (req_progress > ONE) ? ONE : req_progress;
      case (mode_ff)
         MODE_EASE_OUT: x_in = ONE - a_sat;
         MODE_IN_OUT:   x_in = (a_sat < HALF) ? (a_sat << 1) : ((ONE - a_sat) << 1);
         default:       x_in = a_sat;
      endcase
      po_in     = (exponent_ff == '0) || (x_in >= ONE);
      pf_in     = po_in || (x_in == '0);
      step_prod = a_sat * step_count_ff;
      step_q    = step_prod[F +: SB+1];
      d         = step_count_ff - SB'(1);
      num_in    = (NW'(step_q) << F) + NW'(d >> 1);
   end

   logic          v_ff  [1:PR];
   logic [F:0]    a_ff  [1:PR];
   logic          pf_ff [1:PR];
   logic          po_ff [1:PR];
   logic [F:0]    x_ff;
   logic [NW-1:0] num_ff [1:PD-1];
   logic [SB-1:0] rem_ff [2:PD];
   logic [F:0]    quo_ff [2:PR];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[1] <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[1]   <= a_sat;
         pf_ff[1]  <= pf_in;
         po_ff[1]  <= po_in;
         x_ff      <= x_in;
         num_ff[1] <= num_in;
      end
   end

   for (genvar s = 2; s <= PR; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            a_ff[s]  <= a_ff[s-1];
            pf_ff[s] <= pf_ff[s-1];
            po_ff[s] <= po_ff[s-1];
         end
      end
   end

   // ---- step divider: one quotient bit per stage, MSB first
   for (genvar s = 2; s <= PD; s++) begin : g_div
      logic [SB-1:0] rem_prev;
      logic [F:0]    quo_prev;
      logic [SB:0]   trial;
      logic          ge;
      if (s == 2) begin : g_first
         assign rem_prev = num_ff[1][F+1 +: SB];
         assign quo_prev = '0;
      end else begin : g_rest
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end
      assign trial = {rem_prev, num_ff[s-1][PD-s]};
      assign ge    = trial >= {1'b0, d};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= ge ? SB'(trial - {1'b0, d}) : trial[SB-1:0];
            quo_ff[s] <= {quo_prev[F-1:0], ge};
         end
      end
      if (s < PD) begin : g_num
         always_ff @(posedge clock) begin
            if (adv) num_ff[s] <= num_ff[s-1];
         end
      end
   end

   for (genvar s = PD + 1; s <= PR; s++) begin : g_quo
      always_ff @(posedge clock) begin
         if (adv) quo_ff[s] <= quo_ff[s-1];
      end
   end

   // ---- power: log, scale by exponent, exp
   logic [LW-1:0]    log_val;
   logic [LW+EW-1:0] scaled;
   logic [MW-1:0]    mm_ff;
   logic [IPW-1:0]   ip_ff [PM+1:PY];
   logic [YW-1:0]    y_val;

   tec_log #(
      .FRAC_BITS (F)
   ) u_log (
      .clock   (clock),
      .advance (adv),
      .x       (x_ff),
      .log_out (log_val)
   );

   assign scaled = log_val * exponent_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mm_ff        <= scaled[EXP_FRAC_BITS +: MW];
         ip_ff[PM+1]  <= mm_ff[MW-1 -: IPW];
      end
   end

   for (genvar s = PM + 2; s <= PY; s++) begin : g_ip
      always_ff @(posedge clock) begin
         if (adv) ip_ff[s] <= ip_ff[s-1];
      end
   end

   tec_exp u_exp (
      .clock   (clock),
      .advance (adv),
      .frac    (mm_ff[LOG_BITS-1:0]),
      .power   (y_val)
   );

   // ---- rounding to Q1.F
   logic          underflow;
   logic [SW-1:0] rshift;
   logic [YW:0]   rsum, rsh;
   logic [F:0]    pr_in, pr_ff;

   always_comb begin
      underflow = ip_ff[PY] > IPW'(F);
      rshift    = SW'(MANT_BITS + 1 - F) + SW'(ip_ff[PY]);
      rsum      = {1'b0, y_val} + ((YW+1)'(1) << (rshift - SW'(1)));
      rsh       = rsum >> rshift;
      if (pf_ff[PY])
         pr_in = po_ff[PY] ? ONE : '0;
      else if (underflow)
         pr_in = '0;
      else
         pr_in = (rsh > (YW+1)'(ONE)) ? ONE : rsh[F:0];
   end

   always_ff @(posedge clock) begin
      if (adv) pr_ff <= pr_in;
   end

   // ---- curve select
   logic [F:0] a_fin, half_p, eased_in;
   logic [F+1:0] p_inc;

   always_comb begin
      a_fin  = a_ff[PR];
      p_inc  = {1'b0, pr_ff} + (F+2)'(1);
      half_p = p_inc[F+1:1];
      case (mode_ff)
         MODE_JUMP:     eased_in = (a_fin >= ONE) ? ONE : '0;
         MODE_STEP: begin
            if (step_count_ff <= SB'(1) || a_fin == '0)
               eased_in = '0;
            else if (a_fin >= ONE)
               eased_in = ONE;
            else
               eased_in = (quo_ff[PR] > ONE) ? ONE : quo_ff[PR];
         end
         MODE_EASE_IN:  eased_in = pr_ff;
         MODE_EASE_OUT: eased_in = ONE - pr_ff;
         MODE_IN_OUT:   eased_in = (a_fin < HALF) ? half_p : (ONE - half_p);
         default:       eased_in = a_fin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[PR];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_eased_ff <= eased_in;
   end

   `TEC_ASSERT_NOW(a_eased_range, rsp_valid_ff, rsp_eased_ff <= ONE, "eased above 1.0")
   `TEC_ASSERT_NEXT(a_stall_hold, !adv && v_ff[PR], v_ff[PR] && $stable(pr_ff), "pipeline moved during stall")
   `TEC_ASSERT_NEXT(a_linear_pass, adv && v_ff[PR] && mode_ff == MODE_LINEAR, rsp_eased_ff == $past(a_ff[PR]), "linear result differs from progress")

endmodule

### hw/rtl/tec_log.sv
// Pipelined -log2 of a Q.F fraction: leading-one normalize, then one squaring per stage.
// Depends on tec_pkg; a normalize register leads the squaring stages, and all advance on advance.
module tec_log
   import tec_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       advance,
   input  logic [FRAC_BITS:0]                         x,
   output logic [$clog2(FRAC_BITS+1)+LOG_BITS-1:0]    log_out
);

   localparam int CW  = $clog2(FRAC_BITS + 1);
   localparam int LW  = CW + LOG_BITS;
   localparam int MB  = MANT_BITS;
   localparam int SHW = $clog2(MB + 1);

   logic [CW-1:0]       lead;
   logic [SHW-1:0]      norm_shift;
   logic [CW-1:0]       pint_ff [0:LOG_BITS];
   logic [MB:0]         m_ff    [0:LOG_BITS];
   logic [LOG_BITS-1:0] f_ff    [1:LOG_BITS];

   always_comb begin
      lead = '0;
      for (int i = 0; i < FRAC_BITS; i++)
         if (x[i]) lead = CW'(i);
      norm_shift = SHW'(MB) - SHW'(lead);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pint_ff[0] <= CW'(FRAC_BITS) - lead;
         m_ff[0]    <= (MB+1)'(x) << norm_shift;
      end
   end

   for (genvar i = 1; i <= LOG_BITS; i++) begin : g_sq
      logic [2*MB+1:0] sq;
      logic [MB+1:0]   t;
      assign sq = m_ff[i-1] * m_ff[i-1];
      assign t  = sq[MB +: MB+2];
      if (i == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (advance) f_ff[i] <= LOG_BITS'(t[MB+1]);
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (advance) f_ff[i] <= {f_ff[i-1][LOG_BITS-2:0], t[MB+1]};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            m_ff[i]    <= t[MB+1] ? t[MB+1:1] : t[MB:0];
            pint_ff[i] <= pint_ff[i-1];
         end
      end
   end

   assign log_out = {pint_ff[LOG_BITS], {LOG_BITS{1'b0}}} - LW'(f_ff[LOG_BITS]);

endmodule

### hw/rtl/tec_exp.sv
// Pipelined 2^(1-frac) in Q2.30: one conditional multiply by a constant root per stage.
// Depends on tec_pkg for the root table; each multiply stage is registered and advances on advance.
module tec_exp
   import tec_pkg::*;
(
   input  logic                   clock,
   input  logic                   advance,
   input  logic [LOG_BITS-1:0]    frac,
   output logic [MANT_BITS+1:0]   power
);

   localparam int MB = MANT_BITS;
   localparam int YW = MB + 2;
   localparam logic [LOG_BITS:0] G_ONE = {1'b1, {LOG_BITS{1'b0}}};

   logic [LOG_BITS:0] g_in;
   logic [YW-1:0]     y_base;
   logic [LOG_BITS:0] g_ff [1:LOG_BITS];
   logic [YW-1:0]     y_ff [1:LOG_BITS];

   assign g_in   = G_ONE - {1'b0, frac};
   // zero fraction: 2^1, halved later by the output shift
   assign y_base = g_in[LOG_BITS] ? (YW'(2) << MB) : (YW'(1) << MB);

   for (genvar i = 1; i <= LOG_BITS; i++) begin : g_mul
      localparam logic [MB:0] ROOT = (MB+1)'(tec_root(i));
      logic [LOG_BITS:0]  g_prev;
      logic [YW-1:0]      y_prev;
      logic [YW+MB:0]     prod;
      if (i == 1) begin : g_first
         assign g_prev = g_in;
         assign y_prev = y_base;
      end else begin : g_rest
         assign g_prev = g_ff[i-1];
         assign y_prev = y_ff[i-1];
      end
      assign prod = y_prev * ROOT;
      always_ff @(posedge clock) begin
         if (advance) begin
            g_ff[i] <= g_prev;
            y_ff[i] <= g_prev[LOG_BITS-i] ? prod[MB +: YW] : y_prev;
         end
      end
   end

   assign power = y_ff[LOG_BITS];

endmodule
